// ===== rtl/acc_alu_pkg.sv =====
// Package for the accumulator ALU: operation codes, payload and pipeline types,
// and the shared restoring-divide step. No dependencies.
package acc_alu_pkg;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_ADDC = 3'd1,
    OP_SUBB = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_DA   = 3'd5
  } op_e;

  // quotient bits resolved in each pipeline stage (sum is 8)
  localparam int unsigned DivStepsS1 = 3;
  localparam int unsigned DivStepsS2 = 3;
  localparam int unsigned DivStepsS3 = 2;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] acc_value;
    logic [7:0] operand_value;
    logic       carry_in;
    logic       aux_carry_in;
    logic       overflow_in;
  } req_t;

  typedef struct packed {
    logic [7:0] acc_result;
    logic [7:0] b_result;
    logic       carry_out;
    logic       aux_carry_out;
    logic       overflow_out;
    logic       parity_out;
  } rsp_t;

  // divider state: partial remainder and dividend/quotient shift word
  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] dq;
  } div_t;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] b;
    logic       cy;
    logic       ac;
    logic       ov;
    logic       div_op;
    logic       div_zero;
    logic [7:0] divisor;
    div_t       div;
  } pipe_t;

  // one restoring step: shift in next dividend bit, trial subtract
  function automatic div_t div_step(div_t st, logic [7:0] d);
    logic [8:0] t;
    logic       qbit;
    div_t       nx;
    t    = {st.rem, st.dq[7]};
    qbit = (t >= {1'b0, d});
    if (qbit) begin
      t = t - {1'b0, d};
    end
    nx.rem = t[7:0];
    nx.dq  = {st.dq[6:0], qbit};
    return nx;
  endfunction

endpackage

// ===== rtl/acc_alu_if.sv =====
// Valid/ready channel interfaces for the accumulator ALU request and response.
// No dependencies.
interface acc_alu_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] acc_value;
  logic [7:0] operand_value;
  logic       carry_in;
  logic       aux_carry_in;
  logic       overflow_in;

  modport source (
    output valid, req_type, acc_value, operand_value, carry_in, aux_carry_in, overflow_in,
    input  ready
  );
  modport sink (
    input  valid, req_type, acc_value, operand_value, carry_in, aux_carry_in, overflow_in,
    output ready
  );
endinterface

interface acc_alu_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] acc_result;
  logic [7:0] b_result;
  logic       carry_out;
  logic       aux_carry_out;
  logic       overflow_out;
  logic       parity_out;

  modport source (
    output valid, acc_result, b_result, carry_out, aux_carry_out, overflow_out, parity_out,
    input  ready
  );
  modport sink (
    input  valid, acc_result, b_result, carry_out, aux_carry_out, overflow_out, parity_out,
    output ready
  );
endinterface

// ===== rtl/acc_alu_stage1.sv =====
// Stage 1: decode, add/subtract/multiply/decimal adjust, first divide steps.
// Depends on acc_alu_pkg.
module acc_alu_stage1 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  acc_alu_pkg::req_t  req_i,
  output logic               valid_o,
  output acc_alu_pkg::pipe_t pipe_o
);

  acc_alu_pkg::op_e   op;
  acc_alu_pkg::pipe_t pipe_d, pipe_q;
  logic               valid_q;
  logic [7:0]         a, s;
  logic               cy, c_add;
  logic [8:0]         sum9, dif9, da1, da2;
  logic [4:0]         sum_lo, dif_lo;
  logic [15:0]        prod;
  logic               cy1;

  assign op    = acc_alu_pkg::op_e'(req_i.req_type);
  assign a     = req_i.acc_value;
  assign s     = req_i.operand_value;
  assign cy    = req_i.carry_in;
  assign c_add = (op == acc_alu_pkg::OP_ADDC) & cy;

  assign sum9   = {1'b0, a} + {1'b0, s} + {8'd0, c_add};
  assign sum_lo = {1'b0, a[3:0]} + {1'b0, s[3:0]} + {4'd0, c_add};
  assign dif9   = {1'b0, a} - {1'b0, s} - {8'd0, cy};
  assign dif_lo = {1'b0, a[3:0]} - {1'b0, s[3:0]} - {4'd0, cy};
  assign prod   = {8'd0, a} * {8'd0, s};

  // decimal adjust: low nibble fix, then high nibble fix; carry only sets
  assign da1 = ((a[3:0] > 4'd9) || req_i.aux_carry_in) ? {1'b0, a} + 9'd6 : {1'b0, a};
  assign cy1 = cy | da1[8];
  assign da2 = ((da1[7:4] > 4'd9) || cy1) ? {1'b0, da1[7:0]} + 9'h060
                                           : {1'b0, da1[7:0]};

  always_comb begin
    acc_alu_pkg::div_t dv;
    pipe_d          = '0;
    pipe_d.acc      = a;
    pipe_d.b        = s;
    pipe_d.cy       = cy;
    pipe_d.ac       = req_i.aux_carry_in;
    pipe_d.ov       = req_i.overflow_in;
    pipe_d.div_zero = (s == 8'd0);
    pipe_d.divisor  = s;
    dv.rem = 8'd0;
    dv.dq  = a;
    for (int i = 0; i < int'(acc_alu_pkg::DivStepsS1); i++) begin
      dv = acc_alu_pkg::div_step(dv, s);
    end
    pipe_d.div = dv;
    case (op)
      acc_alu_pkg::OP_ADD, acc_alu_pkg::OP_ADDC: begin
        pipe_d.acc = sum9[7:0];
        pipe_d.cy  = sum9[8];
        pipe_d.ac  = sum_lo[4];
        pipe_d.ov  = (a[7] ^ sum9[7]) & (s[7] ^ sum9[7]);
      end
      acc_alu_pkg::OP_SUBB: begin
        pipe_d.acc = dif9[7:0];
        pipe_d.cy  = dif9[8];
        pipe_d.ac  = dif_lo[4];
        pipe_d.ov  = (a[7] ^ s[7]) & (a[7] ^ dif9[7]);
      end
      acc_alu_pkg::OP_MUL: begin
        pipe_d.acc = prod[7:0];
        pipe_d.b   = prod[15:8];
        pipe_d.cy  = 1'b0;
        pipe_d.ov  = |prod[15:8];
      end
      acc_alu_pkg::OP_DIV: begin
        pipe_d.cy     = 1'b0;
        pipe_d.ov     = (s == 8'd0);
        pipe_d.div_op = 1'b1;
      end
      acc_alu_pkg::OP_DA: begin
        pipe_d.acc = da2[7:0];
        pipe_d.cy  = cy1 | da2[8];
      end
      default: begin
        // unused codes: no operation
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

// ===== rtl/acc_alu_stage2.sv =====
// Stage 2: middle divide steps; other results ride along.
// Depends on acc_alu_pkg.
module acc_alu_stage2 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  acc_alu_pkg::pipe_t pipe_i,
  output logic               valid_o,
  output acc_alu_pkg::pipe_t pipe_o
);

  acc_alu_pkg::pipe_t pipe_d, pipe_q;
  logic               valid_q;

  always_comb begin
    acc_alu_pkg::div_t dv;
    pipe_d = pipe_i;
    dv     = pipe_i.div;
    for (int i = 0; i < int'(acc_alu_pkg::DivStepsS2); i++) begin
      dv = acc_alu_pkg::div_step(dv, pipe_i.divisor);
    end
    pipe_d.div = dv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

// ===== rtl/acc_alu_stage3.sv =====
// Stage 3: last divide steps, divide result select, parity, output register.
// Depends on acc_alu_pkg.
module acc_alu_stage3 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  acc_alu_pkg::pipe_t pipe_i,
  output logic               valid_o,
  output acc_alu_pkg::rsp_t  rsp_o
);

  acc_alu_pkg::rsp_t rsp_d, rsp_q;
  logic              valid_q;

  always_comb begin
    acc_alu_pkg::div_t dv;
    dv = pipe_i.div;
    for (int i = 0; i < int'(acc_alu_pkg::DivStepsS3); i++) begin
      dv = acc_alu_pkg::div_step(dv, pipe_i.divisor);
    end
    rsp_d.acc_result    = pipe_i.acc;
    rsp_d.b_result      = pipe_i.b;
    rsp_d.carry_out     = pipe_i.cy;
    rsp_d.aux_carry_out = pipe_i.ac;
    rsp_d.overflow_out  = pipe_i.ov;
    // divide by zero keeps A and B as they came in
    if (pipe_i.div_op && !pipe_i.div_zero) begin
      rsp_d.acc_result = dv.dq;
      rsp_d.b_result   = dv.rem;
    end
    rsp_d.parity_out = ^rsp_d.acc_result;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

// ===== rtl/accumulator_alu_with_flags.sv =====
// Top level of the 8-bit accumulator ALU with flags.
// Depends on acc_alu_pkg, acc_alu_if and the three stage modules.
//
// Usage:
//   req_i carries one operation per transfer: req_type (ADD, ADDC, SUBB, MUL,
//   DIV, DA), the accumulator, the operand (B for MUL/DIV) and CY/AC/OV.
//   rsp_o returns exactly one result per request, in order: new A, new B,
//   CY, AC, OV and parity of the new A.
// Pipeline: from request to response, every operation passes the same three
//   register stages. The 8-step restoring divider sets the depth: its quotient
//   bits are split 3/3/2 over the three register stages.
// Throughput: one transfer per cycle, sustained, while rsp_o.ready is high.
// Stall: each stage holds when the one after it is full and stalled; empty
//   stages keep filling, so req_i.ready drops only once all three stages
//   hold data and rsp_o.ready is low. Nothing is dropped or repeated.
// Reset: rst_ni (async, active low) clears the stage valid bits; the block
//   accepts requests on the first cycle after reset.
module accumulator_alu_with_flags (
  input  logic          clk_i,
  input  logic          rst_ni,
  acc_alu_req_if.sink   req_i,
  acc_alu_rsp_if.source rsp_o
);

  acc_alu_pkg::req_t  req;
  acc_alu_pkg::pipe_t s1_pipe, s2_pipe;
  acc_alu_pkg::rsp_t  rsp;
  logic               s1_valid, s2_valid, s3_valid;
  logic               s1_en, s2_en, s3_en;

  // per-stage advance: a stage loads when it is empty or its data moves on
  assign s3_en = !s3_valid || rsp_o.ready;
  assign s2_en = !s2_valid || s3_en;
  assign s1_en = !s1_valid || s2_en;

  assign req_i.ready = s1_en;

  assign req.req_type      = req_i.req_type;
  assign req.acc_value     = req_i.acc_value;
  assign req.operand_value = req_i.operand_value;
  assign req.carry_in      = req_i.carry_in;
  assign req.aux_carry_in  = req_i.aux_carry_in;
  assign req.overflow_in   = req_i.overflow_in;

  acc_alu_stage1 u_stage1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (s1_en),
    .valid_i (req_i.valid),
    .req_i   (req),
    .valid_o (s1_valid),
    .pipe_o  (s1_pipe)
  );

  acc_alu_stage2 u_stage2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (s2_en),
    .valid_i (s1_valid),
    .pipe_i  (s1_pipe),
    .valid_o (s2_valid),
    .pipe_o  (s2_pipe)
  );

  // last stage register doubles as the output register
  acc_alu_stage3 u_stage3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (s3_en),
    .valid_i (s2_valid),
    .pipe_i  (s2_pipe),
    .valid_o (s3_valid),
    .rsp_o   (rsp)
  );

  assign rsp_o.valid         = s3_valid;
  assign rsp_o.acc_result    = rsp.acc_result;
  assign rsp_o.b_result      = rsp.b_result;
  assign rsp_o.carry_out     = rsp.carry_out;
  assign rsp_o.aux_carry_out = rsp.aux_carry_out;
  assign rsp_o.overflow_out  = rsp.overflow_out;
  assign rsp_o.parity_out    = rsp.parity_out;

endmodule

// ===== rtl/acc_alu_checker.sv =====
// Port-level checker for the accumulator ALU, bound to the top level.
// Depends on accumulator_alu_with_flags and acc_alu_if.
module acc_alu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [7:0] acc_result_i,
  input logic [7:0] b_result_i,
  input logic       carry_out_i,
  input logic       aux_carry_out_i,
  input logic       overflow_out_i,
  input logic       parity_out_i
);

  logic req_xfer;
  assign req_xfer = req_valid_i && req_ready_i;

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(acc_result_i)
      && $stable(b_result_i) && $stable(carry_out_i) && $stable(aux_carry_out_i)
      && $stable(overflow_out_i) && $stable(parity_out_i))
    else $error("response changed while stalled");

  // empty output stage means the pipe can take a request
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_i |-> req_ready_i)
    else $error("request stalled with empty output");

  // parity matches the accumulator shown
  a_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> parity_out_i == ^acc_result_i)
    else $error("parity mismatch");

  // a request transfer followed by rsp_ready held high reaches the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer ##1 rsp_ready_i ##1 rsp_ready_i |=> rsp_valid_i)
    else $error("response missing after three cycles");

endmodule

bind accumulator_alu_with_flags acc_alu_checker u_acc_alu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .acc_result_i    (rsp_o.acc_result),
  .b_result_i      (rsp_o.b_result),
  .carry_out_i     (rsp_o.carry_out),
  .aux_carry_out_i (rsp_o.aux_carry_out),
  .overflow_out_i  (rsp_o.overflow_out),
  .parity_out_i    (rsp_o.parity_out)
);
